[hw/rtl/pfx_pkg.sv]
// Shared types, codes and arithmetic helpers of the postfix evaluator.
package pfx_pkg;

  // Value format: signed fixed point, 16 fraction bits
  localparam int VAL_W  = 48;
  localparam int FRAC_W = 16;
  localparam int ERR_W  = 3;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = 7;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Iteration counts of the shared multiply / divide unit
  localparam logic [CNT_W-1:0] MUL_STEPS = 7'd5;
  localparam logic [CNT_W-1:0] DIV_STEPS = 7'd64;

  // Operator characters
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 3'd0,
    ERR_UNDER = 3'd1,
    ERR_FULL  = 3'd2,
    ERR_DIV0  = 3'd3,
    ERR_SAT   = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPER,
    S_ITER,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch symbol, clear stack on start flag
    logic push;      // write pushed value, sp + 1
    logic rd_older;  // read entry below the top
    logic op_start;  // load operand magnitudes into the mul/div unit
    logic op_step;   // one iteration of the mul/div unit
    logic commit;    // write result over older operand, sp - 1
    logic out_load;  // load the output register
    err_t err;       // error code of this item
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  kind;
    logic sp_full;
    logic sp_lt2;
    logic b_zero;
    logic op_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic             sat;
    logic [VAL_W-1:0] v;
  } res_t;

  function automatic op_t decode_sym(input logic [SYM_W-1:0] s);
    op_t k;
    case (s)
      SYM_PLUS:  k = OP_ADD;
      SYM_MINUS: k = OP_SUB;
      SYM_STAR:  k = OP_MUL;
      SYM_SLASH: k = OP_DIV;
      default:   k = OP_PUSH;
    endcase
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

  // Clamp a magnitude to the signed range, then apply the sign
  function automatic res_t sat_mag(input logic [79:0] m, input logic neg);
    res_t             r;
    logic [79:0]      lim;
    logic [VAL_W-1:0] mm;
    lim   = neg ? {32'b0, VAL_MIN} : {32'b0, VAL_MAX};
    r.sat = (m > lim);
    mm    = r.sat ? lim[VAL_W-1:0] : m[VAL_W-1:0];
    r.v   = neg ? (~mm + VAL_W'(1)) : mm;
    return r;
  endfunction

  // Saturating add / subtract on 49-bit sums
  function automatic res_t add_sat(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                                   input logic sub);
    res_t         r;
    logic [VAL_W:0] s;
    if (sub) begin
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    end else begin
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    end
    r.sat = s[VAL_W] != s[VAL_W-1];
    if (r.sat) begin
      r.v = s[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      r.v = s[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/pfx_ctrl.sv]
// Controller state machine of the postfix evaluator.
module pfx_ctrl import pfx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  err_t   err_r, err_nxt;

  // State and error registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= ERR_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.err   = err_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          err_nxt    = ERR_OK;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind == OP_PUSH) begin
          if (sts.sp_full) begin
            err_nxt = ERR_FULL;
          end else begin
            cmd.push = 1'b1;
          end
          state_nxt = S_RESP;
        end else if (sts.sp_lt2) begin
          err_nxt   = ERR_UNDER;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_older = 1'b1;
          state_nxt    = S_OPER;
        end
      end
      S_OPER: begin
        case (sts.kind)
          OP_ADD, OP_SUB: begin
            cmd.commit = 1'b1;
            state_nxt  = S_RESP;
          end
          OP_MUL: begin
            cmd.op_start = 1'b1;
            state_nxt    = S_ITER;
          end
          OP_DIV: begin
            if (sts.b_zero) begin
              err_nxt   = ERR_DIV0;
              state_nxt = S_RESP;
            end else begin
              cmd.op_start = 1'b1;
              state_nxt    = S_ITER;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_ITER: begin
        if (sts.op_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          cmd.op_step = 1'b1;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/pfx_datapath.sv]
// Datapath of the postfix evaluator: operand stack, mul/div unit, output register.
module pfx_datapath import pfx_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int DW = $clog2(STACK_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_start_new,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_top_value,
  output logic [DW-1:0]    out_depth,
  output logic [ERR_W-1:0] out_error_code
);

  logic [VAL_W-1:0] mem [STACK_DEPTH];

  logic [DW-1:0]    sp_r;
  logic [VAL_W-1:0] top_r;
  logic [SYM_W-1:0] sym_r;
  logic             sat_r;
  logic [VAL_W-1:0] rdata_r;
  logic [VAL_W-1:0] ma_r, mb_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0] prod_r;
  logic [1:0]       psh_r;
  logic [95:0]      acc_r;
  logic [VAL_W-1:0] rem_r;
  logic [63:0]      dvd_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_top_r;
  logic [DW-1:0]    out_depth_r;
  logic [ERR_W-1:0] out_err_r;

  op_t              kind;
  logic [DW-1:0]    sp_m2;
  logic [VAL_W-1:0] push_val;
  logic             is_digit;
  res_t             res;
  logic [23:0]      mul_a, mul_b;
  logic [95:0]      prod_sh;
  logic [VAL_W:0]   div_t;
  logic [VAL_W:0]   div_diff;
  logic             div_ge;

  assign kind     = decode_sym(sym_r);
  assign sp_m2    = sp_r - DW'(2);
  assign is_digit = (sym_r >= SYM_ZERO) && (sym_r <= SYM_NINE);
  assign push_val = is_digit ? {28'b0, sym_r[3:0], 16'b0} : '0;

  // Status to controller
  assign sts.kind     = kind;
  assign sts.sp_full  = (sp_r == DW'(STACK_DEPTH));
  assign sts.sp_lt2   = (sp_r < DW'(2));
  assign sts.b_zero   = (top_r == '0);
  assign sts.op_done  = (kind == OP_MUL) ? (cnt_r == MUL_STEPS) : (cnt_r == DIV_STEPS);
  assign sts.out_free = !out_valid_r || out_ready;

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[sp_r[AW-1:0]] <= push_val;
    end else if (cmd.commit) begin
      mem[sp_m2[AW-1:0]] <= res.v;
    end
    if (cmd.rd_older) begin
      rdata_r <= mem[sp_m2[AW-1:0]];
    end
  end

  // Stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.accept && in_start_new) begin
      sp_r <= '0;
    end else if (cmd.push) begin
      sp_r <= sp_r + DW'(1);
    end else if (cmd.commit) begin
      sp_r <= sp_r - DW'(1);
    end
  end

  // Cached top entry, symbol and saturation flag
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_r <= in_symbol;
      sat_r <= 1'b0;
    end
    if (cmd.push) begin
      top_r <= push_val;
    end else if (cmd.commit) begin
      top_r <= res.v;
      sat_r <= res.sat;
    end
  end

  // Partial product selection: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin mul_a = ma_r[23:0];  mul_b = mb_r[23:0];  end
      2'd1:    begin mul_a = ma_r[23:0];  mul_b = mb_r[47:24]; end
      2'd2:    begin mul_a = ma_r[47:24]; mul_b = mb_r[23:0];  end
      default: begin mul_a = ma_r[47:24]; mul_b = mb_r[47:24]; end
    endcase
    case (psh_r)
      2'd0:    prod_sh = {48'b0, prod_r};
      2'd1:    prod_sh = {24'b0, prod_r, 24'b0};
      2'd2:    prod_sh = {prod_r, 48'b0};
      default: prod_sh = '0;
    endcase
  end

  // Restoring divider, one quotient bit per step
  assign div_t    = {rem_r, dvd_r[63]};
  assign div_diff = div_t - {1'b0, mb_r};
  assign div_ge   = (div_t >= {1'b0, mb_r});

  // Shared multiply / divide unit
  always_ff @(posedge clk) begin
    if (cmd.op_start) begin
      ma_r  <= mag(rdata_r);
      mb_r  <= mag(top_r);
      neg_r <= rdata_r[VAL_W-1] ^ top_r[VAL_W-1];
      cnt_r <= '0;
      acc_r <= '0;
      rem_r <= '0;
      dvd_r <= {mag(rdata_r), 16'b0};
    end else if (cmd.op_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (kind == OP_MUL) begin
        if (cnt_r < CNT_W'(4)) begin
          prod_r <= {24'b0, mul_a} * {24'b0, mul_b};
          psh_r  <= (cnt_r[1:0] == 2'd0) ? 2'd0 : (cnt_r[1:0] == 2'd3) ? 2'd2 : 2'd1;
        end
        if (cnt_r != '0) begin
          acc_r <= acc_r + prod_sh;
        end
      end else begin
        rem_r <= div_ge ? div_diff[VAL_W-1:0] : div_t[VAL_W-1:0];
        dvd_r <= {dvd_r[62:0], div_ge};
      end
    end
  end

  // Result selection with saturation
  always_comb begin
    case (kind)
      OP_ADD:  res = add_sat(rdata_r, top_r, 1'b0);
      OP_SUB:  res = add_sat(rdata_r, top_r, 1'b1);
      OP_MUL:  res = sat_mag(acc_r[95:FRAC_W], neg_r);
      OP_DIV:  res = sat_mag({16'b0, dvd_r}, neg_r);
      default: res = '{sat: 1'b0, v: top_r};
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_top_r   <= (sp_r == '0) ? '0 : top_r;
      out_depth_r <= sp_r;
      out_err_r   <= (cmd.err == ERR_OK && sat_r) ? ERR_SAT : cmd.err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_top_value  = out_top_r;
  assign out_depth      = out_depth_r;
  assign out_error_code = out_err_r;

endmodule

[hw/rtl/postfix_expression_evaluator.sv]
// Postfix expression evaluator, top level. Each input item carries one ASCII
// character: a digit pushes its value, + - * / pop two entries and push
// (older op newer), any other character pushes zero; tuser set empties the
// stack first. Values are signed 48-bit fixed point with 16 fraction bits;
// every item yields one result item with the top entry (0 when empty), the
// depth and an error code (underflow, stack full and divide by zero leave the
// stack unchanged; saturated results are clamped and pushed). One item is
// handled at a time: a push, an underflow or a full stack passes the decode
// and response states, + and - and a divide by zero also the operand state,
// and * and / add an iteration state: * forms four 24x24 partial products on
// one multiplier, / runs the restoring divider that forms one quotient bit per
// cycle. The output register lets the next item in while a result waits. The
// stack is a single-port-read memory with no clearing pass.
module postfix_expression_evaluator import pfx_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  localparam int DW    = $clog2(STACK_DEPTH + 1),
  localparam int OUT_W = ((VAL_W + DW + ERR_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // symbol[7:0]
  input  logic             in_tuser,   // start_new
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // top_value, depth, error_code, zero fill
);

  cmd_t             cmd;
  sts_t             sts;
  logic [VAL_W-1:0] top_value;
  logic [DW-1:0]    depth;
  logic [ERR_W-1:0] error_code;

  pfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfx_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_tdata),
    .in_start_new   (in_tuser),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_top_value  (top_value),
    .out_depth      (depth),
    .out_error_code (error_code)
  );

  // Pack result fields, lowest first
  assign out_tdata = OUT_W'({error_code, depth, top_value});

endmodule
